// ===== rtl/core/tofm_pkg.sv =====
// ----------------------------------------------------------------------------
// tofm_pkg
// Shared types, codes, constants and constant tables of the two-operator
// FM voice: command and register codes, controller states, datapath
// operations, the quarter-wave sine table and the velocity gain table.
// ----------------------------------------------------------------------------
package tofm_pkg;

    localparam int PHASE_W      = 24;
    localparam int SAMPLE_W     = 16;
    localparam int SINE_DEPTH   = 1024;
    localparam int SINE_IDX_W   = $clog2(SINE_DEPTH);
    localparam int QUARTER      = SINE_DEPTH / 4;
    localparam int QUARTER_W    = $clog2(QUARTER);

    localparam logic [23:0] ENV_FULL   = 24'hFFFFFF;
    localparam logic [23:0] ENV_FLOOR  = 24'd1678;
    localparam int          VGAIN_MIN  = 1638;
    localparam int          VEL_FULL_SCALE = 127;
    localparam int          GAIN_035_Q16   = 22938;
    localparam int          MODE_HOT_Q14   = 17695;
    localparam int          MODE_SOFT_Q14  = 14746;
    localparam int          FB_TO_PHASE_Q20  = 1001327;
    localparam int          RAD_TO_PHASE_Q20 = 166886;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // crush divider: 24-bit dividend, four quotient bits per cycle
    localparam int DIV_W        = 24;
    localparam int DIV_BITS     = 4;
    localparam int DIV_STEPS    = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_NOTE_ON = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        TONE_UNITY = 2'd0,
        TONE_HOT   = 2'd1,
        TONE_SOFT  = 2'd2
    } tone_t;

    typedef enum logic [2:0] {
        CFG_MOD_RATIO     = 3'd0,
        CFG_MOD_INDEX     = 3'd1,
        CFG_FEEDBACK      = 3'd2,
        CFG_DECAY_HELD    = 3'd3,
        CFG_DECAY_RELEASE = 3'd4,
        CFG_CRUSH_LEVELS  = 3'd5,
        CFG_TONE_MODE     = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_NOTE_ON,
        OP_RELEASE,
        OP_MSTEP_MUL,
        OP_FB_MUL,
        OP_FB_SCALE,
        OP_MOD_LOOKUP,
        OP_PM_MUL,
        OP_PM_SCALE,
        OP_CAR_LOOKUP,
        OP_ENV_MUL,
        OP_ENV_WRITE,
        OP_GAIN_ENV,
        OP_RND_ENV,
        OP_GAIN_VEL,
        OP_RND_VEL,
        OP_GAIN_035,
        OP_RND_035,
        OP_CRUSH_MUL,
        OP_CRUSH_PREP,
        OP_DIV_STEP,
        OP_CRUSH_DONE,
        OP_TONE_MUL,
        OP_RND_TONE,
        OP_OUT_SAMPLE,
        OP_OUT_SILENT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MSTEP,
        ST_FB_MUL,
        ST_FB_SCALE,
        ST_MOD_LOOKUP,
        ST_PM_MUL,
        ST_PM_SCALE,
        ST_CAR_LOOKUP,
        ST_ENV_MUL,
        ST_ENV_WRITE,
        ST_GAIN_ENV,
        ST_RND_ENV,
        ST_GAIN_VEL,
        ST_RND_VEL,
        ST_GAIN_035,
        ST_RND_035,
        ST_CRUSH_MUL,
        ST_CRUSH_PREP,
        ST_DIV,
        ST_CRUSH_DONE,
        ST_TONE_MUL,
        ST_RND_TONE,
        ST_OUT,
        ST_SILENT_OUT
    } state_t;

    typedef struct packed {
        logic silent;
        logic crush_en;
        logic tone_en;
    } dp_stat_t;

    // Taylor divisors (2k)(2k+1) for k = 1..5
    localparam longint unsigned TAYLOR_DIV [1:5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

    typedef logic [14:0] qtab_t [QUARTER];
    typedef logic [15:0] vtab_t [128];

    // sin(a/QUARTER * pi/2) in Q0.15, evaluated at elaboration
    function automatic logic [14:0] quarter_sine(input int unsigned a);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          r;
        x    = (longint'(a) * HALF_PI_Q30) / QUARTER;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 5; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        r = (sum + 64'sd16384) >>> 15;
        if (r > 32767) r = 32767;
        return r[14:0];
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int i = 0; i < QUARTER; i++) t[i] = quarter_sine(i);
        return t;
    endfunction

    function automatic vtab_t build_vtab();
        vtab_t t;
        int    g;
        for (int i = 0; i < 128; i++) begin
            g = (i * 32768) / VEL_FULL_SCALE;
            if (g < VGAIN_MIN) g = VGAIN_MIN;
            t[i] = g[15:0];
        end
        return t;
    endfunction

    localparam qtab_t       QTAB       = build_qtab();
    localparam logic [14:0] QSINE_PEAK = quarter_sine(QUARTER);
    localparam vtab_t       VEL_GAIN   = build_vtab();

    // full-cycle sine from the quarter-wave table
    function automatic logic signed [15:0] sine_lookup(input logic [SINE_IDX_W-1:0] idx);
        logic [QUARTER_W-1:0] a;
        logic [14:0]          mag;
        logic signed [15:0]   val;
        a = idx[QUARTER_W-1:0];
        if (idx[QUARTER_W]) begin
            if (a == '0) mag = QSINE_PEAK;
            else         mag = QTAB[QUARTER_W'((QUARTER_W+1)'(QUARTER) - {1'b0, a})];
        end else begin
            mag = QTAB[a];
        end
        val = {1'b0, mag};
        return idx[QUARTER_W+1] ? 16'(-val) : val;
    endfunction

endpackage

// ===== rtl/core/tofm_datapath.sv =====
// ----------------------------------------------------------------------------
// tofm_datapath
// Voice state, configuration registers, one shared multiplier, sine
// lookups, rounding, crush divider and the output register.
// ----------------------------------------------------------------------------
module tofm_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tofm_pkg::dp_op_t    op,
    output tofm_pkg::dp_stat_t  stat,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic [22:0]         phase_step,
    input  logic [6:0]          velocity,
    output logic signed [15:0]  sample,
    output logic                voice_active
);
    import tofm_pkg::*;

    logic [15:0] ratio_reg, ratio_next;
    logic [15:0] index_reg, index_next;
    logic [15:0] fb_amt_reg, fb_amt_next;
    logic [23:0] coef_held_reg, coef_held_next;
    logic [23:0] coef_rel_reg, coef_rel_next;
    logic [8:0]  crush_reg, crush_next;
    logic [1:0]  tone_reg, tone_next;

    logic [23:0]        cph_reg, cph_next;
    logic [23:0]        mph_reg, mph_next;
    logic signed [15:0] fbs_reg, fbs_next;
    logic [23:0]        env_reg, env_next;
    logic               gate_reg, gate_next;
    logic [23:0]        cstep_reg, cstep_next;
    logic [15:0]        vg_reg, vg_next;

    logic signed [57:0] prod_reg, prod_next;
    logic signed [17:0] s_reg, s_next;
    logic signed [15:0] mod_reg, mod_next;
    logic               neg_reg, neg_next;
    logic [23:0]        num_reg, num_next;
    logic [9:0]         rem_reg, rem_next;
    logic signed [15:0] sample_reg, sample_next;
    logic               active_reg, active_next;

    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] mul_p;
    logic [23:0]        mod_sum, car_sum;
    logic signed [15:0] mod_sine, car_sine;
    logic signed [57:0] rnd24, rnd15, rnd16, rnd14;
    logic [8:0]         lv;
    logic [23:0]        env_dec;
    logic signed [17:0] qv, qmag;
    logic [9:0]         dr;
    logic [23:0]        dn;

    assign mul_p    = mul_a * mul_b;
    assign mod_sum  = mph_reg + prod_reg[49:26];
    assign car_sum  = cph_reg + prod_reg[46:23];
    assign mod_sine = sine_lookup(mod_sum[PHASE_W-1 -: SINE_IDX_W]);
    assign car_sine = sine_lookup(car_sum[PHASE_W-1 -: SINE_IDX_W]);
    assign rnd24    = prod_reg + 58'sd8388608;
    assign rnd15    = prod_reg + 58'sd16384;
    assign rnd16    = prod_reg + 58'sd32768;
    assign rnd14    = prod_reg + 58'sd8192;
    assign env_dec  = prod_reg[47:24];
    assign qv       = rnd15[32:15];
    assign qmag     = qv[17] ? -qv : qv;
    // level count: small counts act as 64, large ones as 256
    assign lv       = (crush_reg < 9'd64) ? 9'd64 :
                      ((crush_reg > 9'd256) ? 9'd256 : crush_reg);

    assign stat.silent   = !gate_reg && (env_reg < ENV_FLOOR);
    assign stat.crush_en = (crush_reg != '0);
    assign stat.tone_en  = (tone_reg == TONE_HOT) || (tone_reg == TONE_SOFT);

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_MSTEP_MUL: begin mul_a = {9'd0, cstep_reg}; mul_b = {9'd0, ratio_reg}; end
            OP_FB_MUL:    begin mul_a = 33'(fbs_reg); mul_b = {9'd0, fb_amt_reg}; end
            OP_FB_SCALE:
            begin
                mul_a = 33'($signed(prod_reg[31:0]));
                mul_b = 25'(FB_TO_PHASE_Q20);
            end
            OP_PM_MUL:    begin mul_a = 33'(mod_reg); mul_b = {9'd0, index_reg}; end
            OP_PM_SCALE:
            begin
                mul_a = 33'($signed(prod_reg[31:0]));
                mul_b = 25'(RAD_TO_PHASE_Q20);
            end
            OP_ENV_MUL:
            begin
                mul_a = {9'd0, env_reg};
                mul_b = {1'b0, gate_reg ? coef_held_reg : coef_rel_reg};
            end
            OP_GAIN_ENV:  begin mul_a = 33'(s_reg); mul_b = {1'b0, env_reg}; end
            OP_GAIN_VEL:  begin mul_a = 33'(s_reg); mul_b = {9'd0, vg_reg}; end
            OP_GAIN_035:  begin mul_a = 33'(s_reg); mul_b = 25'(GAIN_035_Q16); end
            OP_CRUSH_MUL: begin mul_a = 33'(s_reg); mul_b = {16'd0, lv}; end
            OP_TONE_MUL:
            begin
                mul_a = 33'(s_reg);
                mul_b = (tone_reg == TONE_HOT) ? 25'(MODE_HOT_Q14) : 25'(MODE_SOFT_Q14);
            end
            default: ;
        endcase
    end

    // radix-16 restoring division step
    always_comb
    begin
        dr = rem_reg;
        dn = num_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            dr = {dr[8:0], dn[23]};
            dn = {dn[22:0], 1'b0};
            if (dr >= {1'b0, lv}) begin
                dr    = dr - {1'b0, lv};
                dn[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        ratio_next     = ratio_reg;
        index_next     = index_reg;
        fb_amt_next    = fb_amt_reg;
        coef_held_next = coef_held_reg;
        coef_rel_next  = coef_rel_reg;
        crush_next     = crush_reg;
        tone_next      = tone_reg;
        cph_next       = cph_reg;
        mph_next       = mph_reg;
        fbs_next       = fbs_reg;
        env_next       = env_reg;
        gate_next      = gate_reg;
        cstep_next     = cstep_reg;
        vg_next        = vg_reg;
        prod_next      = mul_p;
        s_next         = s_reg;
        mod_next       = mod_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        sample_next    = sample_reg;
        active_next    = active_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MOD_RATIO:     ratio_next     = cfg_data[15:0];
                CFG_MOD_INDEX:     index_next     = cfg_data[15:0];
                CFG_FEEDBACK:      fb_amt_next    = cfg_data[15:0];
                CFG_DECAY_HELD:    coef_held_next = cfg_data;
                CFG_DECAY_RELEASE: coef_rel_next  = cfg_data;
                CFG_CRUSH_LEVELS:  crush_next     = cfg_data[8:0];
                CFG_TONE_MODE:     tone_next      = cfg_data[1:0];
                default: ;
            endcase
        end

        case (op)
            OP_NOTE_ON:
            begin
                if (phase_step != '0) begin
                    cstep_next = {1'b0, phase_step};
                    vg_next    = VEL_GAIN[velocity];
                    env_next   = ENV_FULL;
                    gate_next  = 1'b1;
                end
            end
            OP_RELEASE:    gate_next = 1'b0;
            OP_FB_MUL:     mph_next  = mph_reg + prod_reg[35:12];
            OP_MOD_LOOKUP:
            begin
                mod_next = mod_sine;
                fbs_next = mod_sine;
                cph_next = cph_reg + cstep_reg;
            end
            OP_CAR_LOOKUP: s_next = 18'(car_sine);
            OP_ENV_WRITE:  env_next = (!gate_reg && env_dec < ENV_FLOOR) ? '0 : env_dec;
            OP_RND_ENV:    s_next = rnd24[41:24];
            OP_RND_VEL:    s_next = rnd15[32:15];
            OP_RND_035:    s_next = rnd16[33:16];
            OP_RND_TONE:   s_next = rnd14[31:14];
            OP_CRUSH_PREP:
            begin
                neg_next = qv[17];
                num_next = {qmag[8:0], 15'd0} + {16'd0, lv[8:1]};
                rem_next = '0;
            end
            OP_DIV_STEP:
            begin
                num_next = dn;
                rem_next = dr;
            end
            OP_CRUSH_DONE:
                s_next = neg_reg ? -$signed(num_reg[17:0]) : $signed(num_reg[17:0]);
            OP_OUT_SAMPLE:
            begin
                if (s_reg > 18'sd32767)       sample_next = 16'sh7FFF;
                else if (s_reg < -18'sd32768) sample_next = 16'sh8000;
                else                          sample_next = s_reg[15:0];
                active_next = gate_reg || (env_reg >= ENV_FLOOR);
            end
            OP_OUT_SILENT:
            begin
                sample_next = '0;
                active_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ratio_reg     <= 16'd8192;
            index_reg     <= 16'd9830;
            fb_amt_reg    <= 16'd3932;
            coef_held_reg <= 24'd16776740;
            coef_rel_reg  <= 24'd16776027;
            crush_reg     <= '0;
            tone_reg      <= TONE_UNITY;
            cph_reg       <= '0;
            mph_reg       <= '0;
            fbs_reg       <= '0;
            env_reg       <= '0;
            gate_reg      <= 1'b0;
            cstep_reg     <= '0;
            vg_reg        <= '0;
        end else begin
            ratio_reg     <= ratio_next;
            index_reg     <= index_next;
            fb_amt_reg    <= fb_amt_next;
            coef_held_reg <= coef_held_next;
            coef_rel_reg  <= coef_rel_next;
            crush_reg     <= crush_next;
            tone_reg      <= tone_next;
            cph_reg       <= cph_next;
            mph_reg       <= mph_next;
            fbs_reg       <= fbs_next;
            env_reg       <= env_next;
            gate_reg      <= gate_next;
            cstep_reg     <= cstep_next;
            vg_reg        <= vg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        s_reg      <= s_next;
        mod_reg    <= mod_next;
        neg_reg    <= neg_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        sample_reg <= sample_next;
        active_reg <= active_next;
    end

    assign sample       = sample_reg;
    assign voice_active = active_reg;

endmodule

// ===== rtl/core/tofm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tofm_ctrl
// Sequencer of the voice: input and output handshakes, per-tick operation
// sequence and the crush divider step count.
// ----------------------------------------------------------------------------
module tofm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    output logic               out_valid,
    input  logic               out_ready,
    input  tofm_pkg::dp_stat_t stat,
    output tofm_pkg::dp_op_t   op
);
    import tofm_pkg::*;

    state_t                state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                  slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_cnt_next   = div_cnt_reg;
        op             = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    unique case (command)
                        CMD_TICK:    state_next = stat.silent ? ST_SILENT_OUT : ST_MSTEP;
                        CMD_NOTE_ON: op = OP_NOTE_ON;
                        CMD_RELEASE: op = OP_RELEASE;
                        default: ;
                    endcase
                end
            end
            ST_MSTEP:      begin op = OP_MSTEP_MUL;  state_next = ST_FB_MUL;     end
            ST_FB_MUL:     begin op = OP_FB_MUL;     state_next = ST_FB_SCALE;   end
            ST_FB_SCALE:   begin op = OP_FB_SCALE;   state_next = ST_MOD_LOOKUP; end
            ST_MOD_LOOKUP: begin op = OP_MOD_LOOKUP; state_next = ST_PM_MUL;     end
            ST_PM_MUL:     begin op = OP_PM_MUL;     state_next = ST_PM_SCALE;   end
            ST_PM_SCALE:   begin op = OP_PM_SCALE;   state_next = ST_CAR_LOOKUP; end
            ST_CAR_LOOKUP: begin op = OP_CAR_LOOKUP; state_next = ST_ENV_MUL;    end
            ST_ENV_MUL:    begin op = OP_ENV_MUL;    state_next = ST_ENV_WRITE;  end
            ST_ENV_WRITE:  begin op = OP_ENV_WRITE;  state_next = ST_GAIN_ENV;   end
            ST_GAIN_ENV:   begin op = OP_GAIN_ENV;   state_next = ST_RND_ENV;    end
            ST_RND_ENV:    begin op = OP_RND_ENV;    state_next = ST_GAIN_VEL;   end
            ST_GAIN_VEL:   begin op = OP_GAIN_VEL;   state_next = ST_RND_VEL;    end
            ST_RND_VEL:    begin op = OP_RND_VEL;    state_next = ST_GAIN_035;   end
            ST_GAIN_035:   begin op = OP_GAIN_035;   state_next = ST_RND_035;    end
            ST_RND_035:
            begin
                op = OP_RND_035;
                if (stat.crush_en)     state_next = ST_CRUSH_MUL;
                else if (stat.tone_en) state_next = ST_TONE_MUL;
                else                   state_next = ST_OUT;
            end
            ST_CRUSH_MUL:  begin op = OP_CRUSH_MUL;  state_next = ST_CRUSH_PREP; end
            ST_CRUSH_PREP:
            begin
                op           = OP_CRUSH_PREP;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                op = OP_DIV_STEP;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_CRUSH_DONE;
                else div_cnt_next = div_cnt_reg + 1'b1;
            end
            ST_CRUSH_DONE:
            begin
                op         = OP_CRUSH_DONE;
                state_next = stat.tone_en ? ST_TONE_MUL : ST_OUT;
            end
            ST_TONE_MUL:   begin op = OP_TONE_MUL;   state_next = ST_RND_TONE;   end
            ST_RND_TONE:   begin op = OP_RND_TONE;   state_next = ST_OUT;        end
            ST_OUT:
            begin
                if (slot_free) begin
                    op             = OP_OUT_SAMPLE;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SILENT_OUT:
            begin
                if (slot_free) begin
                    op             = OP_OUT_SILENT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/two_operator_fm_voice_core.sv =====
// Tick: one pass through the state sequence of the single shared multiplier; tone gain
// and crush add states. A new tick is taken only after the last result is registered.
// Silent tick: the silent output state registers the result. Note on and release: no result.
// Reset (rst_n low, asynchronous): voice state cleared, registers to their defaults,
// output empty, input ready.
// ----------------------------------------------------------------------------
// two_operator_fm_voice_core
// Two-operator FM voice with self-fed modulator, exponential envelope,
// gain chain, optional requantization and output tone gain.
// ----------------------------------------------------------------------------
module two_operator_fm_voice_core (
    input  logic               clk,
    input  logic               rst_n,
    // input transactions
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [22:0]        phase_step,
    input  logic [6:0]         velocity,
    // result transactions
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample,
    output logic               voice_active,
    // register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import tofm_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;

    // Register writes land in the registers directly; never stall them.
    assign cfg_ready = 1'b1;

    // Controller: holds the handshakes and steps the datapath through one
    // tick: modulator phase, feedback, modulator sine, phase modulation,
    // carrier sine, envelope decay, gain chain, crush and tone gain.
    tofm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .op        (op)
    );

    // Datapath: voice state, registers and the output register that parts
    // the result from the next transaction.
    tofm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .phase_step   (phase_step),
        .velocity     (velocity),
        .sample       (sample),
        .voice_active (voice_active)
    );

endmodule

// ===== rtl/core/tofm_checker.sv =====
// ----------------------------------------------------------------------------
// tofm_checker
// Port-level checks of the FM voice, bound to the top level.
// ----------------------------------------------------------------------------
module tofm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] sample,
    input logic        voice_active
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(voice_active))
        else $error("stalled result changed");

    // an inactive voice outputs silence
    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !voice_active |-> sample == 16'd0)
        else $error("inactive voice gave nonzero sample");

    // ready drops only after a transaction
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input ready dropped without transaction");

    // a result appears only at the end of a tick in progress
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without tick in progress");

endmodule

bind two_operator_fm_voice_core tofm_checker u_checker (.*);

// ===== tb/fm_voice_checker.sv =====
// ----------------------------------------------------------------------------
// fm_voice_checker
// Watches the input, result and register-write channels of the FM voice,
// predicts every sample and compares it field by field.
// ----------------------------------------------------------------------------
module fm_voice_checker
    import tofm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         command,
    input  logic [22:0]        phase_step,
    input  logic [6:0]         velocity,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] sample,
    input  logic               voice_active,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output int                 fail_count,
    output int                 pending_count,
    output int                 sample_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] smp;
        logic               act;
    } voice_out_t;

    voice_out_t expected_samples[$];

    logic [15:0] r_ratio, r_index, r_fb;
    logic [23:0] r_held, r_rel;
    logic [8:0]  r_crush;
    logic [1:0]  r_tone;

    logic [23:0] car_ph, mod_ph, car_step, env;
    logic signed [15:0] fb_smp;
    logic [15:0] vel_gain;
    logic        gate;
    logic signed [15:0] sine_rom [SINE_DEPTH];

    function automatic longint fdiv(longint v, int s);
        longint m;
        if (v >= 0) return v >>> s;
        m = -v;
        m = (m + (64'sd1 <<< s) - 1) >>> s;
        return -m;
    endfunction

    function automatic longint rdiv(longint v, int s);
        return fdiv(v + (64'sd1 <<< (s - 1)), s);
    endfunction

    function automatic logic [14:0] qsine(longint unsigned a);
        longint unsigned x, term;
        longint sum, r;
        x = a * HALF_PI_Q30 / QUARTER;
        term = x;
        sum = x;
        for (int k = 1; k <= 5; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k & 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        r = (sum + 16384) >>> 15;
        if (r > 32767) r = 32767;
        return r[14:0];
    endfunction

    function automatic longint sine_at(longint unsigned ph);
        longint unsigned p;
        p = ph & 64'hFFFFFF;
        return sine_rom[(p * SINE_DEPTH) >> PHASE_W];
    endfunction

    task automatic reset_voice();
        int a;
        logic signed [15:0] v;
        r_ratio = 8192; r_index = 9830; r_fb = 3932;
        r_held = 16776740; r_rel = 16776027; r_crush = 0; r_tone = TONE_UNITY;
        car_ph = 0; mod_ph = 0; car_step = 0; env = 0; fb_smp = 0;
        vel_gain = 0; gate = 0;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            a = i % QUARTER;
            v = {1'b0, ((i / QUARTER) & 1) ? qsine(QUARTER - a) : qsine(a)};
            sine_rom[i] = ((i / QUARTER) & 2) ? -v : v;
        end
    endtask

    task automatic voice_step(logic [1:0] c, logic [22:0] st, logic [6:0] vel);
        longint fbv, md, pm, s, lv, qv, r;
        longint unsigned ms, m, e;
        voice_out_t o;
        if (c == CMD_NOTE_ON)
        begin
            if (st == 0) return;
            car_step = {1'b0, st};
            r = (longint'(vel) << 15) / 127;
            vel_gain = (r < VGAIN_MIN) ? 16'(VGAIN_MIN) : 16'(r);
            env = ENV_FULL;
            gate = 1;
            return;
        end
        if (c == CMD_RELEASE)
        begin
            gate = 0;
            return;
        end
        if (c != CMD_TICK) return;
        if (!gate && env < ENV_FLOOR)
        begin
            o.smp = 0; o.act = 0;
            expected_samples.push_back(o);
            return;
        end
        ms = (longint'(car_step) * r_ratio) >> 12;
        mod_ph = 24'(mod_ph + ms);
        fbv = fdiv(longint'(fb_smp) * r_fb * FB_TO_PHASE_Q20, 26);
        md = sine_at(longint'(mod_ph) + fbv);
        fb_smp = 16'(md);
        car_ph = 24'(car_ph + car_step);
        pm = fdiv(md * r_index * RAD_TO_PHASE_Q20, 23);
        s = sine_at(longint'(car_ph) + pm);
        e = (longint'(env) * (gate ? r_held : r_rel)) >> 24;
        env = 24'(e);
        if (!gate && env < ENV_FLOOR) env = 0;
        s = rdiv(s * env, 24);
        s = rdiv(s * vel_gain, 15);
        s = rdiv(s * GAIN_035_Q16, 16);
        if (r_crush != 0)
        begin
            lv = (r_crush < 64) ? 64 : ((r_crush > 256) ? 256 : r_crush);
            qv = rdiv(s * lv, 15);
            m = (qv < 0) ? -qv : qv;
            r = ((m << 15) + lv / 2) / lv;
            s = (qv < 0) ? -r : r;
        end
        if (r_tone == TONE_HOT) s = rdiv(s * MODE_HOT_Q14, 14);
        else if (r_tone == TONE_SOFT) s = rdiv(s * MODE_SOFT_Q14, 14);
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        o.smp = 16'(s);
        o.act = gate || env >= ENV_FLOOR;
        expected_samples.push_back(o);
    endtask

    initial
    begin
        fail_count = 0;
        sample_count = 0;
        pending_count = 0;
        reset_voice();
    end

    always @(posedge clk)
    begin
        voice_out_t e;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MOD_RATIO:     r_ratio = cfg_data[15:0];
                    CFG_MOD_INDEX:     r_index = cfg_data[15:0];
                    CFG_FEEDBACK:      r_fb    = cfg_data[15:0];
                    CFG_DECAY_HELD:    r_held  = cfg_data;
                    CFG_DECAY_RELEASE: r_rel   = cfg_data;
                    CFG_CRUSH_LEVELS:  r_crush = cfg_data[8:0];
                    CFG_TONE_MODE:     r_tone  = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                sample_count++;
                if (expected_samples.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected sample %0d active %0b", $time, sample,
                             voice_active);
                end
                else
                begin
                    e = expected_samples.pop_front();
                    if (e.smp !== sample || e.act !== voice_active)
                    begin
                        fail_count++;
                        $display("%0t: expected sample %0d active %0b, got %0d active %0b",
                                 $time, e.smp, e.act, sample, voice_active);
                    end
                end
            end
            if (in_valid && in_ready) voice_step(command, phase_step, velocity);
            pending_count = expected_samples.size();
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives note-on, release and tick transactions with random idling and
// register settings into the FM voice; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import tofm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic [22:0]        phase_step;
    logic [6:0]         velocity;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] sample;
    logic               voice_active;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;
    int                 fail_count;
    int                 pending_count;
    int                 sample_count;

    // idle percentages of each side; hold_off forces a long receiver stall
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  items_sent;

    two_operator_fm_voice_core u_top (.*);

    fm_voice_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Receiver: stall at random, or for a long stretch while hold_off is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one transaction; drop any finished register write, idle before it
    // at random with valid low, then hold until accepted. Valid stays high
    // after the accept so that the next transaction can follow directly.
    task automatic send_item(logic [1:0] c, logic [22:0] st, logic [6:0] vel);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= c;
        phase_step <= st;
        velocity   <= vel;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Write one register; valid drops when the next transaction is sent.
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Drop input valid, drain every expected sample, then let a tail of the
    // longest tick pass.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Note-on step: mostly low pitches, sometimes the full range.
    function automatic logic [22:0] pick_step();
        case ($urandom_range(3))
            0: return 23'($urandom_range(8388607));
            1: return 23'($urandom_range(1, 4000));
            default: return 23'($urandom_range(1, 400000));
        endcase
    endfunction

    // One phrase: note on, a run of ticks, at times a second note on, a release, a tail of ticks.
    task automatic play_phrase();
        int n;
        send_item(CMD_NOTE_ON, pick_step(), 7'($urandom));
        n = $urandom_range(2, 20);
        repeat (n) send_item(CMD_TICK, 23'($urandom), 7'($urandom));
        if ($urandom_range(9) == 0)
            send_item(CMD_NOTE_ON, 23'($urandom_range(1) ? 0 : $urandom), 7'($urandom));
        send_item(CMD_RELEASE, 23'($urandom), 7'($urandom));
        n = $urandom_range(1, 12);
        repeat (n) send_item(CMD_TICK, 23'($urandom), 7'($urandom));
        // noise: an unused command
        if ($urandom_range(7) == 0) send_item(2'd3, 23'($urandom), 7'($urandom));
    endtask

    // Random register setting; extremes appear often.
    task automatic random_settings();
        write_reg(CFG_MOD_RATIO, $urandom_range(3) == 0 ? 24'(($urandom_range(1)) ? 1024 : 32768)
                                                        : 24'($urandom_range(1024, 32768)));
        write_reg(CFG_MOD_INDEX, 24'($urandom_range(32768)));
        write_reg(CFG_FEEDBACK, 24'($urandom_range(32768)));
        // fast decays so release tails reach the floor within a phrase
        write_reg(CFG_DECAY_HELD, 24'($urandom_range(14000000, 16777215)));
        write_reg(CFG_DECAY_RELEASE, $urandom_range(3) == 0 ? 24'(0)
                                                           : 24'($urandom_range(8000000, 16777215)));
        write_reg(CFG_CRUSH_LEVELS, 24'($urandom_range(511)));
        write_reg(CFG_TONE_MODE, 24'($urandom_range(3)));
    endtask

    // Long receiver stall, counted in cycles while the sender keeps offering.
    initial
    begin
        hold_off = 0;
        wait (items_sent > 300);
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
    end

    initial
    begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0; command = CMD_TICK; phase_step = 0; velocity = 0;
        cfg_valid = 0; cfg_index = CFG_MOD_RATIO; cfg_data = 0;
        send_idle_pct = 0; recv_idle_pct = 0; items_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: silent voice, extremes of step and velocity, zero step ignored.
        send_item(CMD_TICK, 23'h7FFFFF, 7'h7F);
        send_item(CMD_NOTE_ON, 23'd0, 7'd100);
        send_item(CMD_TICK, 0, 0);
        send_item(CMD_NOTE_ON, 23'h7FFFFF, 7'd127);
        send_item(CMD_TICK, 0, 0);
        send_item(CMD_TICK, 0, 0);
        send_item(CMD_NOTE_ON, 23'd1, 7'd0);
        send_item(CMD_TICK, 0, 0);
        send_item(CMD_NOTE_ON, 23'd30000, 7'd3);
        send_item(CMD_TICK, 0, 0);
        send_item(2'd3, 23'h7FFFFF, 7'h7F);
        send_item(CMD_RELEASE, 0, 0);
        send_item(CMD_TICK, 0, 0);
        drain();

        // Max-stress settings: instant release fade, crush and tone extremes.
        write_reg(CFG_MOD_RATIO, 24'd32768);
        write_reg(CFG_MOD_INDEX, 24'd32768);
        write_reg(CFG_FEEDBACK, 24'd32768);
        write_reg(CFG_DECAY_HELD, 24'hFFFFFF);
        write_reg(CFG_DECAY_RELEASE, 24'd0);
        write_reg(CFG_CRUSH_LEVELS, 24'd1);
        write_reg(CFG_TONE_MODE, 24'(TONE_HOT));
        write_reg(3'd7, 24'hFFFFFF);
        send_item(CMD_NOTE_ON, 23'd123457, 7'd127);
        repeat (4) send_item(CMD_TICK, 0, 0);
        send_item(CMD_RELEASE, 0, 0);
        repeat (2) send_item(CMD_TICK, 0, 0);
        drain();
        write_reg(CFG_MOD_RATIO, 24'd1024);
        write_reg(CFG_MOD_INDEX, 24'd0);
        write_reg(CFG_FEEDBACK, 24'd0);
        write_reg(CFG_DECAY_HELD, 24'd0);
        write_reg(CFG_CRUSH_LEVELS, 24'd511);
        write_reg(CFG_TONE_MODE, 24'(TONE_SOFT));
        send_item(CMD_NOTE_ON, 23'd5000, 7'd64);
        repeat (3) send_item(CMD_TICK, 0, 0);
        drain();

        // Random phrases in three idling phases, new settings before each block of phrases.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 24 : ((ph == 1) ? 59 : 0);
            recv_idle_pct = (ph == 0) ? 59 : ((ph == 1) ? 24 : 0);
            for (int blk = 0; blk < 4; blk++)
            begin
                random_settings();
                repeat (6) play_phrase();
                drain();
            end
        end

        drain();
        $display("Ran %0d input transactions and checked %0d samples across", items_sent,
                 sample_count);
        $display("random register settings, idling phases and a long output stall.");
        if (fail_count == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/tofm_pkg.sv
rtl/core/tofm_datapath.sv
rtl/core/tofm_ctrl.sv
rtl/core/two_operator_fm_voice_core.sv
rtl/core/tofm_checker.sv
tb/fm_voice_checker.sv
tb/tb_top.sv
